/* sv/flconv_pkg.sv */
package flconv_pkg;

    // Fixed field widths of the item and result payloads.
    localparam int TAP_W       = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int RESULT_W    = 38;
    localparam int IDX_W       = 5;
    localparam int COUNT_W     = 6;

    // Default number of cells in the chain.
    localparam int TAPS_DEFAULT = 32;

    // Item modes.
    localparam logic MODE_TAP    = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic                          mode;
        logic [IDX_W-1:0]              tap_index;
        logic signed [TAP_W-1:0]       tap_value;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result;
        logic                       result_last;
    } res_t;

    // Controls shared by every cell of the chain.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage

/* sv/flconv_cell.sv */
module flconv_cell (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  flconv_pkg::cell_ctl_t                         ctl,
    input  logic                                          tap_we,
    input  logic signed [flconv_pkg::TAP_W-1:0]           tap_wdata,
    input  logic signed [flconv_pkg::SAMPLE_BITS-1:0]     smp_in,
    input  logic                                          mac_en,
    input  logic signed [flconv_pkg::RESULT_W-1:0]        psum_in,
    output logic signed [flconv_pkg::SAMPLE_BITS-1:0]     smp_out,
    output logic signed [flconv_pkg::RESULT_W-1:0]        psum_out
);
    import flconv_pkg::*;

    localparam int PROD_W = TAP_W + SAMPLE_BITS;

    logic signed [TAP_W-1:0]       tap_reg;
    logic signed [TAP_W-1:0]       tap_next;
    logic signed [SAMPLE_BITS-1:0] smp_reg;
    logic signed [SAMPLE_BITS-1:0] smp_next;
    logic signed [RESULT_W-1:0]    psum_reg;
    logic signed [RESULT_W-1:0]    psum_next;
    logic signed [PROD_W-1:0]      prod;
    logic signed [RESULT_W-1:0]    prod_ext;

    assign tap_next = tap_we ? tap_wdata : tap_reg;

    always_comb
    begin
        if (ctl.clear)
        begin
            smp_next = '0;
        end
        else if (ctl.shift)
        begin
            smp_next = smp_in;
        end
        else
        begin
            smp_next = smp_reg;
        end
    end

    // The partial sum moves one cell to the right each cycle.
    assign prod      = tap_reg * smp_reg;
    assign prod_ext  = RESULT_W'(prod);
    assign psum_next = psum_in + (mac_en ? prod_ext : RESULT_W'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
            smp_reg <= '0;
        end
        else
        begin
            tap_reg <= tap_next;
            smp_reg <= smp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        psum_reg <= psum_next;
    end

    assign smp_out  = smp_reg;
    assign psum_out = psum_reg;

endmodule

/* sv/full_linear_convolution_top.sv */
// Channel   Direction  Payload             Transfer when
// item      in         item_t              item_valid && item_ready
// res       out        res_t               res_valid && res_ready
// cfg       in         tap_count (6 bits)  cfg_valid && cfg_ready
//
// A tap write leaves the block ready for the next item. After a sample no new
// item is taken until its sweep has run and its result has been handed off;
// each tail result of a marked trace end takes a sweep of its own. A sweep is
// the partial sum walking the chain, one cell per cycle, across all TAPS cells.
// Reset clears the taps, the sample line and the control; there is no
// clearing pass. A stalled result waits in the output register while the
// chain holds its finished sum.
module full_linear_convolution_top #(
    parameter int TAPS = flconv_pkg::TAPS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  flconv_pkg::item_t                   item,
    output logic                                res_valid,
    input  logic                                res_ready,
    output flconv_pkg::res_t                    res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [flconv_pkg::COUNT_W-1:0]      cfg_data
);
    import flconv_pkg::*;

    localparam int M_W   = $clog2(TAPS + 1);
    localparam int CNT_W = $clog2(TAPS);
    localparam int TL_W  = $clog2(TAPS);

    // Controller states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [TL_W-1:0]    tail_reg;
    logic [TL_W-1:0]    tail_next;
    logic               last_pend_reg;
    logic               last_pend_next;
    logic [COUNT_W-1:0] tap_count_reg;
    logic [COUNT_W-1:0] tap_count_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    res_t               res_data_reg;
    res_t               res_data_next;

    logic [M_W-1:0]     act_taps;
    logic               item_acc;
    logic               tap_wr;
    logic               smp_acc;
    logic               res_free;
    logic               handoff;
    logic               final_res;
    cell_ctl_t          ctl;

    logic signed [SAMPLE_BITS-1:0] smp_chain  [TAPS+1];
    logic signed [RESULT_W-1:0]    psum_chain [TAPS+1];

    // A count of zero runs one tap; a count beyond the chain runs all cells.
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            act_taps = M_W'(1);
        end
        else if (int'(tap_count_reg) > TAPS)
        begin
            act_taps = M_W'(TAPS);
        end
        else
        begin
            act_taps = M_W'(tap_count_reg);
        end
    end

    assign item_ready = (state_reg == ST_IDLE);
    assign item_acc   = item_valid && item_ready;
    assign tap_wr     = item_acc && (item.mode == MODE_TAP);
    assign smp_acc    = item_acc && (item.mode == MODE_SAMPLE);

    assign res_free  = !res_valid_reg || res_ready;
    assign handoff   = (state_reg == ST_DONE) && res_free;
    assign final_res = last_pend_reg && (tail_reg == '0);

    // A new sample or a zero for the tail enters cell 0; the line is emptied
    // once the final result of a trace has been handed to the output register.
    assign ctl.shift = smp_acc || (handoff && (tail_reg != '0));
    assign ctl.clear = handoff && final_res;

    assign smp_chain[0]  = smp_acc ? item.sample : SAMPLE_BITS'(0);
    assign psum_chain[0] = '0;

    genvar i;
    generate
        for (i = 0; i < TAPS; i++)
        begin : g_cell
            flconv_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .tap_we    (tap_wr && (int'(item.tap_index) == i)),
                .tap_wdata (item.tap_value),
                .smp_in    (smp_chain[i]),
                .mac_en    (M_W'(i) < act_taps),
                .psum_in   (psum_chain[i]),
                .smp_out   (smp_chain[i+1]),
                .psum_out  (psum_chain[i+1])
            );
        end
    endgenerate

    // Sequencer: the samples stay frozen while the partial sum crosses the
    // chain, so by the end of the sweep the last cell holds the complete sum.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        tail_next      = tail_reg;
        last_pend_next = last_pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (smp_acc)
                begin
                    state_next     = ST_SWEEP;
                    cnt_next       = '0;
                    last_pend_next = item.last;
                    tail_next      = item.last ? TL_W'(act_taps - M_W'(1)) : '0;
                end
            end
            ST_SWEEP:
            begin
                if (cnt_reg == CNT_W'(TAPS - 1))
                begin
                    state_next = ST_DONE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (handoff)
                begin
                    if (tail_reg != '0)
                    begin
                        state_next = ST_SWEEP;
                        tail_next  = tail_reg - TL_W'(1);
                    end
                    else
                    begin
                        state_next     = ST_IDLE;
                        last_pend_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Output register: parts the chain from the result consumer.
    always_comb
    begin
        res_data_next = res_data_reg;
        if (handoff)
        begin
            res_valid_next            = 1'b1;
            res_data_next.result      = psum_chain[TAPS];
            res_data_next.result_last = final_res;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    assign tap_count_next = cfg_valid ? cfg_data : tap_count_reg;
    assign cfg_ready      = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            tail_reg      <= '0;
            last_pend_reg <= 1'b0;
            tap_count_reg <= COUNT_W'(32);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tail_reg      <= tail_next;
            last_pend_reg <= last_pend_next;
            tap_count_reg <= tap_count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_data_reg;

    // A finished sum that finds the output register free always lands there.
    a_handoff_loads: assert property (@(posedge clk) disable iff (!rst_n)
        handoff |=> res_valid_reg)
        else $error("finished sum was not loaded into the output register");

    // Tail results are only owed while a trace end is pending.
    a_tail_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg != '0) |-> last_pend_reg)
        else $error("tail count set without a pending trace end");

    // After the final result the sample line is empty and the block is idle.
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (handoff && final_res) |=> (state_reg == ST_IDLE) && (smp_chain[1] == '0))
        else $error("sample line not cleared after final result");

    // The sweep counter only runs during a sweep.
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SWEEP) |-> (cnt_reg == '0))
        else $error("sweep counter active outside a sweep");

endmodule
